### rtl/wfr_pkg.sv
`timescale 1ns / 1ps

package wfr_pkg;

    // control sequencer
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CRC    = 5'b00010,
        ST_RESULT = 5'b00100,
        ST_READ   = 5'b01000,
        ST_LOAD   = 5'b10000
    } t_ctrl;

    // frame parser phase
    typedef enum logic [4:0] {
        PH_FEND = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_CMD  = 5'b00100,
        PH_NBT  = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    localparam logic [2:0] REG_OWN_ADDR = 3'd0;
    localparam logic [2:0] REG_CRC_SEED = 3'd1;
    localparam logic [2:0] REG_FEND     = 3'd2;
    localparam logic [2:0] REG_FESC     = 3'd3;
    localparam logic [2:0] REG_TFEND    = 3'd4;
    localparam logic [2:0] REG_TFESC    = 3'd5;

    localparam logic [7:0] CRC_POLY      = 8'h18;
    localparam logic [6:0] RST_OWN_ADDR  = 7'd0;
    localparam logic [7:0] RST_CRC_SEED  = 8'd222;
    localparam logic [7:0] RST_FEND      = 8'd192;
    localparam logic [7:0] RST_FESC      = 8'd219;
    localparam logic [7:0] RST_TFEND     = 8'd220;
    localparam logic [7:0] RST_TFESC     = 8'd221;

endpackage

### rtl/wfr_ram.sv
`timescale 1ns / 1ps

module wfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/wake_frame_receiver_top.sv
// a byte that feeds the crc is accepted, then stepped through the serial crc bit by bit; others need no crc steps
// no new byte is taken while the bit-serial crc shift register works: tready stays low until it is done
// a good frame streams its payload word by word, each a ram read then an output load that waits on tready
// error and empty-frame results pass through the result state into the output register once it is free
// reset: synchronous active-low, clears parser state and loads register defaults
`timescale 1ns / 1ps

module wake_frame_receiver_top
    import wfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // line_error

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // command, byte_count, payload_byte, zero pad
    output logic [1:0]  m_axis_tuser,   // status, payload_valid
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);
    localparam logic [5:0] MAX_C = 6'(MAX_PAYLOAD);

    logic [6:0] r_own;
    logic [7:0] r_seed, r_fend, r_fesc, r_tfend, r_tfesc;

    t_ctrl      r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [7:0] r_prev, n_prev;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_sh, n_sh;
    logic [2:0] r_bit, n_bit;
    logic [6:0] r_cmd, n_cmd;
    logic [5:0] r_len, n_len;
    logic [5:0] r_wpos, n_wpos;
    logic [5:0] r_k, n_k;
    logic       r_res_err, n_res_err;

    logic       r_ov, n_ov;
    logic       r_o_status, n_o_status;
    logic [6:0] r_o_cmd, n_o_cmd;
    logic [5:0] r_o_cnt, n_o_cnt;
    logic [7:0] r_o_data, n_o_data;
    logic       r_o_pv, n_o_pv;
    logic       r_o_last, n_o_last;

    logic       ram_we;
    logic [7:0] ram_rdata;

    logic [7:0] b;
    logic       pre_esc;
    logic       dec_ok;
    logic [7:0] d;
    logic       out_free;
    logic       crc_fb;
    logic [7:0] crc_x;
    logic       cfg_wr;
    logic       k_last;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own   <= RST_OWN_ADDR;
            r_seed  <= RST_CRC_SEED;
            r_fend  <= RST_FEND;
            r_fesc  <= RST_FESC;
            r_tfend <= RST_TFEND;
            r_tfesc <= RST_TFESC;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_OWN_ADDR: r_own   <= pwdata[6:0];
                REG_CRC_SEED: r_seed  <= pwdata[7:0];
                REG_FEND:     r_fend  <= pwdata[7:0];
                REG_FESC:     r_fesc  <= pwdata[7:0];
                REG_TFEND:    r_tfend <= pwdata[7:0];
                REG_TFESC:    r_tfesc <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_OWN_ADDR: prdata = {25'd0, r_own};
            REG_CRC_SEED: prdata = {24'd0, r_seed};
            REG_FEND:     prdata = {24'd0, r_fend};
            REG_FESC:     prdata = {24'd0, r_fesc};
            REG_TFEND:    prdata = {24'd0, r_tfend};
            REG_TFESC:    prdata = {24'd0, r_tfesc};
            default:      prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign b = s_axis_tdata;

    // unstuffing, escaped-escape code wins when both codes match
    assign pre_esc = (r_prev == r_fesc);
    assign dec_ok  = (b == r_tfesc) || (b == r_tfend);
    assign d       = !pre_esc ? b : ((b == r_tfesc) ? r_fesc : r_fend);

    assign out_free = !r_ov || m_axis_tready;
    assign crc_x    = r_crc ^ CRC_POLY;
    assign crc_fb   = r_sh[0] ^ r_crc[0];
    assign k_last   = ((r_k + 6'd1) == r_len);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_prev     = r_prev;
        n_crc      = r_crc;
        n_sh       = r_sh;
        n_bit      = r_bit;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_wpos     = r_wpos;
        n_k        = r_k;
        n_res_err  = r_res_err;
        n_ov       = r_ov && !m_axis_tready;
        n_o_status = r_o_status;
        n_o_cmd    = r_o_cmd;
        n_o_cnt    = r_o_cnt;
        n_o_data   = r_o_data;
        n_o_pv     = r_o_pv;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        n_phase   = PH_FEND;
                        n_res_err = 1'b1;
                        n_state   = ST_RESULT;
                    end else if (b == r_fend) begin
                        n_prev  = b;
                        n_phase = PH_ADDR;
                        n_crc   = r_seed;
                        n_sh    = b;
                        n_bit   = 3'd0;
                        n_state = ST_CRC;
                    end else if (r_phase != PH_FEND) begin
                        n_prev = b;
                        if (pre_esc && !dec_ok) begin
                            n_phase   = PH_FEND;
                            n_res_err = 1'b1;
                            n_state   = ST_RESULT;
                        end else if (!pre_esc && (b == r_fesc)) begin
                            n_prev = b;
                        end else if ((r_phase == PH_ADDR) && d[7]) begin
                            if ((d[6:0] == 7'd0) || (d[6:0] == r_own)) begin
                                n_sh    = {1'b0, d[6:0]};
                                n_bit   = 3'd0;
                                n_phase = PH_CMD;
                                n_state = ST_CRC;
                            end else begin
                                n_phase = PH_FEND;
                            end
                        end else if ((r_phase == PH_ADDR) || (r_phase == PH_CMD)) begin
                            if (d[7]) begin
                                n_phase   = PH_FEND;
                                n_res_err = 1'b1;
                                n_state   = ST_RESULT;
                            end else begin
                                n_cmd   = d[6:0];
                                n_sh    = d;
                                n_bit   = 3'd0;
                                n_phase = PH_NBT;
                                n_state = ST_CRC;
                            end
                        end else if (r_phase == PH_NBT) begin
                            if (d > MAX_B) begin
                                n_phase   = PH_FEND;
                                n_res_err = 1'b1;
                                n_state   = ST_RESULT;
                            end else begin
                                n_len   = d[5:0];
                                n_wpos  = 6'd0;
                                n_sh    = d;
                                n_bit   = 3'd0;
                                n_phase = PH_DATA;
                                n_state = ST_CRC;
                            end
                        end else if (r_wpos < r_len) begin
                            ram_we  = (r_wpos < MAX_C);
                            n_wpos  = r_wpos + 6'd1;
                            n_sh    = d;
                            n_bit   = 3'd0;
                            n_state = ST_CRC;
                        end else if (d != r_crc) begin
                            n_phase   = PH_FEND;
                            n_res_err = 1'b1;
                            n_state   = ST_RESULT;
                        end else begin
                            n_phase = PH_FEND;
                            if (r_len == 6'd0) begin
                                n_res_err = 1'b0;
                                n_state   = ST_RESULT;
                            end else begin
                                n_k     = 6'd0;
                                n_state = ST_READ;
                            end
                        end
                    end
                end
            end
            ST_CRC: begin
                // one crc bit per cycle, lsb first
                n_crc = crc_fb ? {1'b1, crc_x[7:1]} : {1'b0, r_crc[7:1]};
                n_sh  = {1'b0, r_sh[7:1]};
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res_err;
                    n_o_cmd    = r_res_err ? 7'd0 : r_cmd;
                    n_o_cnt    = 6'd0;
                    n_o_data   = 8'd0;
                    n_o_pv     = 1'b0;
                    n_o_last   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = 1'b0;
                    n_o_cmd    = r_cmd;
                    n_o_cnt    = r_len;
                    n_o_data   = ram_rdata;
                    n_o_pv     = 1'b1;
                    n_o_last   = k_last;
                    if (k_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 6'd1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_FEND;
            r_prev    <= 8'd0;
            r_crc     <= 8'd0;
            r_cmd     <= 7'd0;
            r_len     <= 6'd0;
            r_wpos    <= 6'd0;
            r_k       <= 6'd0;
            r_bit     <= 3'd0;
            r_res_err <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_prev    <= n_prev;
            r_crc     <= n_crc;
            r_cmd     <= n_cmd;
            r_len     <= n_len;
            r_wpos    <= n_wpos;
            r_k       <= n_k;
            r_bit     <= n_bit;
            r_res_err <= n_res_err;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh       <= n_sh;
        r_o_status <= n_o_status;
        r_o_cmd    <= n_o_cmd;
        r_o_cnt    <= n_o_cnt;
        r_o_data   <= n_o_data;
        r_o_pv     <= n_o_pv;
        r_o_last   <= n_o_last;
    end

    wfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos[AW-1:0]),
        .i_wdata (d),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'd0, r_o_data, r_o_cnt, r_o_cmd};
    assign m_axis_tuser  = {r_o_pv, r_o_status};
    assign m_axis_tlast  = r_o_last;

endmodule

### test/wfr_checker.sv
`timescale 1ns / 1ps

package wfr_tb_pkg;

    import wfr_pkg::*;

    typedef struct packed {
        logic       status;
        logic [6:0] command;
        logic [5:0] byte_count;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       last;
    } t_rx_result;

    // reflected crc-8, lsb first
    function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] d);
        for (int i = 0; i < 8; i++) begin
            if (d[0] ^ crc[0]) begin
                crc = ((crc ^ CRC_POLY) >> 1) | 8'h80;
            end else begin
                crc = crc >> 1;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

module wfr_checker
    import wfr_pkg::*;
    import wfr_tb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    logic [6:0] own_addr;
    logic [7:0] crc_seed;
    logic [7:0] fend_code;
    logic [7:0] esc_code;
    logic [7:0] tfend_code;
    logic [7:0] tfesc_code;

    t_phase     phase;
    logic [7:0] prev_raw;
    logic [7:0] frame_crc;
    logic [6:0] held_cmd;
    logic [5:0] frame_len;
    logic [5:0] wr_pos;
    logic [7:0] payload_mem [MAX_PAYLOAD];

    t_rx_result rx_results_due[$];
    int         err_count = 0;

    function automatic void reset_model();
        own_addr   = RST_OWN_ADDR;
        crc_seed   = RST_CRC_SEED;
        fend_code  = RST_FEND;
        esc_code   = RST_FESC;
        tfend_code = RST_TFEND;
        tfesc_code = RST_TFESC;
        phase      = PH_FEND;
        prev_raw   = 8'd0;
        frame_crc  = 8'd0;
        held_cmd   = 7'd0;
        frame_len  = 6'd0;
        wr_pos     = 6'd0;
        rx_results_due.delete();
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [7:0] val);
        case (idx)
            REG_OWN_ADDR: own_addr   = val[6:0];
            REG_CRC_SEED: crc_seed   = val;
            REG_FEND:     fend_code  = val;
            REG_FESC:     esc_code   = val;
            REG_TFEND:    tfend_code = val;
            REG_TFESC:    tfesc_code = val;
            default: ;
        endcase
    endfunction

    function automatic void push_result(logic status, logic [6:0] cmd, logic [5:0] cnt,
                                        logic [7:0] data, logic valid, logic last);
        t_rx_result r;
        r.status        = status;
        r.command       = cmd;
        r.byte_count    = cnt;
        r.payload_byte  = data;
        r.payload_valid = valid;
        r.last          = last;
        rx_results_due.push_back(r);
    endfunction

    function automatic void flag_rx_error();
        phase = PH_FEND;
        push_result(1'b1, 7'd0, 6'd0, 8'd0, 1'b0, 1'b1);
    endfunction

    function automatic void decode_rx_byte(logic [7:0] rx, logic line_err);
        logic [7:0] b;
        logic [7:0] pre;
        b = rx;
        if (line_err) begin
            flag_rx_error();
            return;
        end
        if (b == fend_code) begin
            prev_raw  = b;
            phase     = PH_ADDR;
            frame_crc = crc8_step(crc_seed, b);
            return;
        end
        if (phase == PH_FEND) return;

        pre      = prev_raw;
        prev_raw = b;
        if (pre == esc_code) begin
            if (b == tfesc_code) begin
                b = esc_code;
            end else if (b == tfend_code) begin
                b = fend_code;
            end else begin
                flag_rx_error();
                return;
            end
        end else if (b == esc_code) begin
            return;
        end

        if (phase == PH_ADDR) begin
            if (b[7]) begin
                if (b[6:0] == 7'd0 || b[6:0] == own_addr) begin
                    frame_crc = crc8_step(frame_crc, {1'b0, b[6:0]});
                    phase     = PH_CMD;
                end else begin
                    phase = PH_FEND;
                end
                return;
            end
            phase = PH_CMD;
        end

        case (phase)
            PH_CMD: begin
                if (b[7]) begin
                    flag_rx_error();
                    return;
                end
                held_cmd  = b[6:0];
                frame_crc = crc8_step(frame_crc, b);
                phase     = PH_NBT;
            end
            PH_NBT: begin
                if (b > MAX_PAYLOAD) begin
                    flag_rx_error();
                    return;
                end
                frame_len = b[5:0];
                frame_crc = crc8_step(frame_crc, b);
                wr_pos    = 6'd0;
                phase     = PH_DATA;
            end
            default: begin
                if (wr_pos < frame_len) begin
                    payload_mem[wr_pos] = b;
                    wr_pos    = wr_pos + 6'd1;
                    frame_crc = crc8_step(frame_crc, b);
                    return;
                end
                if (b != frame_crc) begin
                    flag_rx_error();
                    return;
                end
                phase = PH_FEND;
                if (frame_len == 6'd0) begin
                    push_result(1'b0, held_cmd, 6'd0, 8'd0, 1'b0, 1'b1);
                end else begin
                    for (int k = 0; k < frame_len; k++) begin
                        push_result(1'b0, held_cmd, frame_len, payload_mem[k], 1'b1,
                                    k == frame_len - 1);
                    end
                end
            end
        endcase
    endfunction

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, exp_v, got_v);
            err_count++;
        end
    endtask

    task automatic check_result();
        t_rx_result exp_r;
        if (rx_results_due.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual tdata %h tuser %b tlast %b",
                     $time, i_m_tdata, i_m_tuser, i_m_tlast);
            err_count++;
        end else begin
            exp_r = rx_results_due.pop_front();
            check_field("status", int'(exp_r.status), int'(i_m_tuser[0]));
            check_field("command", int'(exp_r.command), int'(i_m_tdata[6:0]));
            check_field("byte_count", int'(exp_r.byte_count), int'(i_m_tdata[12:7]));
            check_field("payload_byte", int'(exp_r.payload_byte), int'(i_m_tdata[20:13]));
            check_field("pad", 0, int'(i_m_tdata[23:21]));
            check_field("payload_valid", int'(exp_r.payload_valid), int'(i_m_tuser[1]));
            check_field("last", int'(exp_r.last), int'(i_m_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_s_tvalid && i_s_tready) decode_rx_byte(i_s_tdata, i_s_tuser);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                write_reg(i_paddr[4:2], i_pwdata[7:0]);
            end
        end
        o_pending <= rx_results_due.size();
        o_errors  <= err_count;
    end

endmodule

### test/wake_frame_receiver_top_tb.sv
`timescale 1ns / 1ps

module wake_frame_receiver_top_tb;

    import wfr_pkg::*;
    import wfr_tb_pkg::*;

    localparam int MAX_PAYLOAD    = 32;
    localparam int HOLD_CYCLES    = 2000;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 24;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;   // rx_byte
    logic        s_axis_tuser  = 1'b0;   // line_error
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // command, byte_count, payload_byte, zero pad
    logic [1:0]  m_axis_tuser;           // status, payload_valid
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = 5'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int rx_pending;
    int check_errors;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic long_hold    = 1'b0;
    int hold_cnt       = 0;
    int quiet_cycles   = 0;
    int words_sent     = 0;

    logic [6:0] cfg_own   = RST_OWN_ADDR;
    logic [7:0] cfg_seed  = RST_CRC_SEED;
    logic [7:0] cfg_fend  = RST_FEND;
    logic [7:0] cfg_esc   = RST_FESC;
    logic [7:0] cfg_tfend = RST_TFEND;
    logic [7:0] cfg_tfesc = RST_TFESC;

    logic [7:0] raw_q[$];
    logic       err_q[$];
    logic [7:0] data_q[$];

    wake_frame_receiver_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    wfr_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_errors   (check_errors),
        .o_pending  (rx_pending)
    );

    always #1 i_clk = ~i_clk;

    // receiver side, with an optional long hold-off
    always @(posedge i_clk) begin
        if (long_hold && hold_cnt < HOLD_CYCLES) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt + 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!long_hold) hold_cnt <= 0;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_word(logic [7:0] b, logic e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= e;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_raw();
        foreach (raw_q[i]) push_word(raw_q[i], err_q[i]);
        raw_q.delete();
        err_q.delete();
    endtask

    task automatic raw_word(logic [7:0] b, logic e);
        raw_q.push_back(b);
        err_q.push_back(e);
    endtask

    task automatic put_stuffed(logic [7:0] b);
        if (b == cfg_fend) begin
            raw_word(cfg_esc, 1'b0);
            raw_word(cfg_tfend, 1'b0);
        end else if (b == cfg_esc) begin
            raw_word(cfg_esc, 1'b0);
            raw_word(cfg_tfesc, 1'b0);
        end else begin
            raw_word(b, 1'b0);
        end
    endtask

    // frame from data_q, appended to raw_q
    task automatic build_frame(logic with_addr, logic [6:0] addr, logic [7:0] cmd,
                               logic [7:0] len, logic [7:0] crc_flip);
        logic [7:0] crc;
        crc = crc8_step(cfg_seed, cfg_fend);
        raw_word(cfg_fend, 1'b0);
        if (with_addr) begin
            put_stuffed({1'b1, addr});
            crc = crc8_step(crc, {1'b0, addr});
        end
        put_stuffed(cmd);
        crc = crc8_step(crc, cmd);
        put_stuffed(len);
        crc = crc8_step(crc, len);
        foreach (data_q[i]) begin
            put_stuffed(data_q[i]);
            crc = crc8_step(crc, data_q[i]);
        end
        put_stuffed(crc ^ crc_flip);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return cfg_fend;
            1:       return cfg_esc;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_frame();
        int         n;
        int         kind;
        int         idx;
        logic       with_addr;
        logic [6:0] addr;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] flip;
        data_q.delete();
        n = ($urandom_range(0, 9) == 0) ? MAX_PAYLOAD : $urandom_range(0, 5);
        repeat (n) data_q.push_back(pick_byte());
        addr = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 3))
            0: with_addr = 1'b0;
            1: begin
                with_addr = 1'b1;
                addr      = 7'd0;
            end
            2: begin
                with_addr = 1'b1;
                addr      = cfg_own;
            end
            default: with_addr = 1'b1;
        endcase
        kind = $urandom_range(0, 13);
        cmd  = (kind == 2) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127));
        len  = (kind == 0) ? 8'($urandom_range(MAX_PAYLOAD + 1, 255)) : 8'(n);
        flip = (kind == 1) ? (8'd1 << $urandom_range(0, 7)) : 8'd0;
        build_frame(with_addr, addr, cmd, len, flip);
        idx = $urandom_range(1, raw_q.size() - 1);
        case (kind)
            3: raw_q[idx] = raw_q[idx] ^ (8'd1 << $urandom_range(0, 7));
            4: err_q[idx] = 1'b1;
            5: begin
                repeat ($urandom_range(1, raw_q.size() - 1)) begin
                    void'(raw_q.pop_back());
                    void'(err_q.pop_back());
                end
            end
            6: begin
                raw_q.insert(idx, 8'($urandom_range(0, 255)));
                err_q.insert(idx, 1'b0);
            end
            default: ;
        endcase
        // stray line noise ahead of the frame
        if ($urandom_range(0, 7) == 0) begin
            raw_q.push_front(8'($urandom_range(0, 255)));
            err_q.push_front(1'b0);
        end
        send_raw();
    endtask

    task automatic run_traffic(int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words) random_frame();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (rx_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [6:0] own, logic [7:0] seed, logic [7:0] fend,
                              logic [7:0] esc, logic [7:0] tfend, logic [7:0] tfesc);
        wait_drained();
        reg_write(REG_OWN_ADDR, {1'b0, own});
        reg_write(REG_CRC_SEED, seed);
        reg_write(REG_FEND, fend);
        reg_write(REG_FESC, esc);
        reg_write(REG_TFEND, tfend);
        reg_write(REG_TFESC, tfesc);
        cfg_own   = own;
        cfg_seed  = seed;
        cfg_fend  = fend;
        cfg_esc   = esc;
        cfg_tfend = tfend;
        cfg_tfesc = tfesc;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases at reset settings
        raw_word(8'h00, 1'b1);
        send_raw();
        data_q.delete();
        build_frame(1'b0, 7'd0, 8'h7F, 8'd0, 8'd0);
        send_raw();
        data_q = '{cfg_fend, cfg_esc};
        build_frame(1'b1, 7'd0, 8'h00, 8'd2, 8'd0);
        send_raw();
        // foreign address, then noise outside a frame
        raw_word(cfg_fend, 1'b0);
        raw_word(8'h85, 1'b0);
        raw_word(8'hFF, 1'b0);
        // frame end right after escape, then a bad escape pair
        raw_word(cfg_fend, 1'b0);
        raw_word(cfg_esc, 1'b0);
        raw_word(cfg_fend, 1'b0);
        raw_word(cfg_esc, 1'b0);
        raw_word(8'h00, 1'b0);
        // command with bit 7 set
        raw_word(cfg_fend, 1'b0);
        raw_word(8'h80, 1'b0);
        raw_word(8'h81, 1'b0);
        // oversize length
        raw_word(cfg_fend, 1'b0);
        raw_word(8'h01, 1'b0);
        raw_word(8'(MAX_PAYLOAD + 1), 1'b0);
        send_raw();
        data_q.delete();
        build_frame(1'b0, 7'd0, 8'h01, 8'd0, 8'h01);
        // line error inside a frame
        raw_word(cfg_fend, 1'b0);
        raw_word(8'h05, 1'b0);
        raw_word(8'h3C, 1'b1);
        send_raw();

        set_config(7'd127, 8'h00, 8'h00, 8'hFF, 8'h01, 8'hFE);
        send_idle_pct = 45;
        run_traffic(20);

        set_config(7'd42, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F);
        send_idle_pct = 0;
        recv_stall_pct <= 45;
        run_traffic(20);

        set_config(7'd5, 8'h5A, RST_FEND, RST_FESC, RST_TFEND, RST_TFESC);
        send_idle_pct = 21;
        recv_stall_pct <= 21;
        run_traffic(15);
        // fill the block while the receiver holds off
        long_hold <= 1'b1;
        repeat (2) begin
            data_q.delete();
            repeat (MAX_PAYLOAD) data_q.push_back(pick_byte());
            build_frame(1'b1, cfg_own, 8'($urandom_range(0, 127)), 8'(MAX_PAYLOAD), 8'd0);
            send_raw();
        end
        wait_drained();
        long_hold <= 1'b0;
        run_traffic(5);

        // both escaped codes equal
        set_config(7'd1, 8'hA5, 8'h7E, 8'h7D, 8'h33, 8'h33);
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        run_traffic(15);

        // frame end equal to escape
        set_config(7'd0, 8'h10, 8'h55, 8'h55, 8'h10, 8'h11);
        run_traffic(10);

        wait_drained();
        if (check_errors == 0 && rx_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
rtl/wfr_pkg.sv
rtl/wfr_ram.sv
rtl/wake_frame_receiver_top.sv
test/wfr_checker.sv
test/wake_frame_receiver_top_tb.sv
